>>> design/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Widths, payload types and the square-root step shared by the refraction
// pipeline.
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int CW     = 16;          // Q2.14 component / Q4.12 ratio
    localparam int PROD_W = 2 * CW;      // I_i * N_i
    localparam int DOT_W  = 33;          // cos, Q.28
    localparam int COSN_W = DOT_W + CW;  // cos * N_i
    localparam int SUM_W  = 50;          // I_i*2^28 + cos*N_i
    localparam int T_W    = 21;          // t_i, Q.14
    localparam int TE_W   = 38;          // t_i * eta
    localparam int P_W    = 25;          // p_i, Q.14
    localparam int SQ_W   = 2 * P_W;     // p_i^2
    localparam int L_W    = 52;          // |P|^2 and 1 - |P|^2
    localparam int RAD_W  = 50;          // sqrt radicand
    localparam int S_W    = RAD_W / 2;   // sqrt root
    localparam int REM_W  = S_W + 3;     // sqrt remainder
    localparam int SN_W   = S_W + 1 + CW; // s * N_i
    localparam int OV_W   = 44;          // p_i*2^14 - s*N_i

    localparam int SQ_STAGES = 5;
    localparam int SQ_STEPS  = S_W / SQ_STAGES;

    localparam logic signed [SUM_W-1:0] T_RND  = SUM_W'(1) << 27;
    localparam logic signed [TE_W-1:0]  P_RND  = TE_W'(1) << 11;
    localparam logic signed [OV_W-1:0]  O_RND  = OV_W'(1) << 13;
    localparam logic signed [DOT_W:0]   ONE_Q28 = (DOT_W + 1)'(1) << 28;
    localparam logic signed [L_W-1:0]   ONE_L   = L_W'(1) << 28;

    typedef struct packed {
        logic [2:0][P_W-1:0] p;
        logic [2:0][CW-1:0]  nrm;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [S_W-1:0]   root;
    } sqrt_st_t;

    // one digit of the restoring square root
    function automatic sqrt_st_t sqrt_step(sqrt_st_t st);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] tr;
        sqrt_st_t         o;
        r  = {st.rem[REM_W-3:0], st.rad[RAD_W-1:RAD_W-2]};
        tr = {1'b0, st.root, 2'b01};
        o.rad = {st.rad[RAD_W-3:0], 2'b00};
        if (r >= tr)
        begin
            o.rem  = r - tr;
            o.root = {st.root[S_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {st.root[S_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

>>> design/rfd_vec.sv
// ----------------------------------------------------------------------------
// rfd_vec
// Eight stages: dot product, cosine clamp, perpendicular part P and the
// radicand |1 - |P|^2|.
// ----------------------------------------------------------------------------
module rfd_vec (
    input  logic                          clk,
    input  logic [7:0]                    en,
    input  logic signed [rfd_pkg::CW-1:0] incident_x,
    input  logic signed [rfd_pkg::CW-1:0] incident_y,
    input  logic signed [rfd_pkg::CW-1:0] incident_z,
    input  logic signed [rfd_pkg::CW-1:0] normal_x,
    input  logic signed [rfd_pkg::CW-1:0] normal_y,
    input  logic signed [rfd_pkg::CW-1:0] normal_z,
    input  logic [rfd_pkg::CW-1:0]        refraction_ratio,
    output logic [rfd_pkg::RAD_W-1:0]     rad,
    output rfd_pkg::side_t                side
);

    localparam int CW = rfd_pkg::CW;

    logic signed [CW-1:0] inc_a [3];
    logic signed [CW-1:0] nrm_a [3];

    logic signed [CW-1:0] inc1_reg [3];
    logic signed [CW-1:0] inc2_reg [3];
    logic signed [CW-1:0] inc3_reg [3];
    logic signed [CW-1:0] nrm_reg  [8][3];
    logic [CW-1:0]        eta_reg  [4];

    logic signed [rfd_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [rfd_pkg::PROD_W-1:0] prod_next [3];
    logic signed [rfd_pkg::DOT_W-1:0]  cos_reg, cos_next;
    logic signed [rfd_pkg::COSN_W-1:0] cosn_reg [3];
    logic signed [rfd_pkg::COSN_W-1:0] cosn_next [3];
    logic signed [rfd_pkg::T_W-1:0]    t_reg [3];
    logic signed [rfd_pkg::T_W-1:0]    t_next [3];
    logic signed [rfd_pkg::TE_W-1:0]   te_reg [3];
    logic signed [rfd_pkg::TE_W-1:0]   te_next [3];
    logic signed [rfd_pkg::P_W-1:0]    p6_reg [3];
    logic signed [rfd_pkg::P_W-1:0]    p6_next [3];
    logic signed [rfd_pkg::P_W-1:0]    p7_reg [3];
    logic signed [rfd_pkg::P_W-1:0]    p8_reg [3];
    logic signed [rfd_pkg::SQ_W-1:0]   psq_reg [3];
    logic signed [rfd_pkg::SQ_W-1:0]   psq_next [3];
    logic [rfd_pkg::RAD_W-1:0]         rad_reg, rad_next;

    assign inc_a[0] = incident_x;
    assign inc_a[1] = incident_y;
    assign inc_a[2] = incident_z;
    assign nrm_a[0] = normal_x;
    assign nrm_a[1] = normal_y;
    assign nrm_a[2] = normal_z;

    always_comb
    begin
        logic signed [rfd_pkg::DOT_W:0]   dot;
        logic signed [rfd_pkg::DOT_W:0]   neg;
        logic signed [rfd_pkg::SUM_W-1:0] sum;
        logic signed [rfd_pkg::TE_W-1:0]  tr;
        logic signed [rfd_pkg::L_W-1:0]   len;
        logic signed [rfd_pkg::L_W-1:0]   dif;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = inc_a[i] * nrm_a[i];
        end
        dot = (rfd_pkg::DOT_W + 1)'(prod_reg[0]) + (rfd_pkg::DOT_W + 1)'(prod_reg[1])
            + (rfd_pkg::DOT_W + 1)'(prod_reg[2]);
        neg = -dot;
        if (neg > rfd_pkg::ONE_Q28)
        begin
            neg = rfd_pkg::ONE_Q28;
        end
        cos_next = neg[rfd_pkg::DOT_W-1:0];
        len = '0;
        for (int i = 0; i < 3; i++)
        begin
            cosn_next[i] = cos_reg * nrm_reg[1][i];
            sum = (rfd_pkg::SUM_W'(inc3_reg[i]) <<< 28) + rfd_pkg::SUM_W'(cosn_reg[i])
                + rfd_pkg::T_RND;
            t_next[i] = sum[rfd_pkg::T_W+27:28];
            te_next[i] = t_reg[i] * $signed({1'b0, eta_reg[3]});
            tr = te_reg[i] + rfd_pkg::P_RND;
            p6_next[i] = tr[rfd_pkg::P_W+11:12];
            psq_next[i] = p6_reg[i] * p6_reg[i];
            len = len + rfd_pkg::L_W'(psq_reg[i]);
        end
        dif = rfd_pkg::ONE_L - len;
        if (dif < 0)
        begin
            dif = -dif;
        end
        rad_next = dif[rfd_pkg::RAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg   <= prod_next;
            inc1_reg   <= inc_a;
            nrm_reg[0] <= nrm_a;
            eta_reg[0] <= refraction_ratio;
        end
        if (en[1])
        begin
            cos_reg    <= cos_next;
            inc2_reg   <= inc1_reg;
            nrm_reg[1] <= nrm_reg[0];
            eta_reg[1] <= eta_reg[0];
        end
        if (en[2])
        begin
            cosn_reg   <= cosn_next;
            inc3_reg   <= inc2_reg;
            nrm_reg[2] <= nrm_reg[1];
            eta_reg[2] <= eta_reg[1];
        end
        if (en[3])
        begin
            t_reg      <= t_next;
            nrm_reg[3] <= nrm_reg[2];
            eta_reg[3] <= eta_reg[2];
        end
        if (en[4])
        begin
            te_reg     <= te_next;
            nrm_reg[4] <= nrm_reg[3];
        end
        if (en[5])
        begin
            p6_reg     <= p6_next;
            nrm_reg[5] <= nrm_reg[4];
        end
        if (en[6])
        begin
            psq_reg    <= psq_next;
            p7_reg     <= p6_reg;
            nrm_reg[6] <= nrm_reg[5];
        end
        if (en[7])
        begin
            rad_reg    <= rad_next;
            p8_reg     <= p7_reg;
            nrm_reg[7] <= nrm_reg[6];
        end
    end

    assign rad = rad_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side.p[i]   = p8_reg[i];
            side.nrm[i] = nrm_reg[7][i];
        end
    end

endmodule

>>> design/rfd_sqrt.sv
// ----------------------------------------------------------------------------
// rfd_sqrt
// Pipelined integer square root, a few root bits per stage; the side
// payload rides along.
// ----------------------------------------------------------------------------
module rfd_sqrt (
    input  logic [rfd_pkg::SQ_STAGES-1:0] en,
    input  logic                          clk,
    input  logic [rfd_pkg::RAD_W-1:0]     rad,
    input  rfd_pkg::side_t                side_in,
    output logic [rfd_pkg::S_W-1:0]       root,
    output rfd_pkg::side_t                side_out
);

    localparam int NS = rfd_pkg::SQ_STAGES;

    rfd_pkg::sqrt_st_t st_reg  [NS];
    rfd_pkg::sqrt_st_t st_next [NS];
    rfd_pkg::side_t    side_reg [NS];

    always_comb
    begin
        rfd_pkg::sqrt_st_t w;
        w.rad  = rad;
        w.rem  = '0;
        w.root = '0;
        for (int j = 0; j < rfd_pkg::SQ_STEPS; j++)
        begin
            w = rfd_pkg::sqrt_step(w);
        end
        st_next[0] = w;
        for (int k = 1; k < NS; k++)
        begin
            w = st_reg[k-1];
            for (int j = 0; j < rfd_pkg::SQ_STEPS; j++)
            begin
                w = rfd_pkg::sqrt_step(w);
            end
            st_next[k] = w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0]   <= st_next[0];
            side_reg[0] <= side_in;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                st_reg[k]   <= st_next[k];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign root     = st_reg[NS-1].root;
    assign side_out = side_reg[NS-1];

endmodule

>>> design/rfd_out.sv
// ----------------------------------------------------------------------------
// rfd_out
// Two stages: s * N_i, then P - s*N rounded to Q2.14 and saturated.
// ----------------------------------------------------------------------------
module rfd_out (
    input  logic                           clk,
    input  logic [1:0]                     en,
    input  logic [rfd_pkg::S_W-1:0]        root,
    input  rfd_pkg::side_t                 side,
    output logic signed [rfd_pkg::CW-1:0]  refracted_x,
    output logic signed [rfd_pkg::CW-1:0]  refracted_y,
    output logic signed [rfd_pkg::CW-1:0]  refracted_z
);

    localparam int CW = rfd_pkg::CW;

    logic signed [rfd_pkg::SN_W-1:0] sn_reg  [3];
    logic signed [rfd_pkg::SN_W-1:0] sn_next [3];
    logic signed [rfd_pkg::P_W-1:0]  p_reg   [3];
    logic signed [CW-1:0]            o_reg   [3];
    logic signed [CW-1:0]            o_next  [3];

    always_comb
    begin
        logic signed [rfd_pkg::OV_W-1:0] v;
        logic signed [rfd_pkg::OV_W-15:0] r;
        for (int i = 0; i < 3; i++)
        begin
            sn_next[i] = $signed({1'b0, root}) * $signed(side.nrm[i]);
            v = (rfd_pkg::OV_W'(p_reg[i]) <<< 14) - rfd_pkg::OV_W'(sn_reg[i])
              + rfd_pkg::O_RND;
            r = v[rfd_pkg::OV_W-1:14];
            if (r > (rfd_pkg::OV_W - 14)'(32767))
            begin
                o_next[i] = CW'(32767);
            end
            else if (r < -(rfd_pkg::OV_W - 14)'(32768))
            begin
                o_next[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                o_next[i] = r[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sn_reg <= sn_next;
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= $signed(side.p[i]);
            end
        end
        if (en[1])
        begin
            o_reg <= o_next;
        end
    end

    assign refracted_x = o_reg[0];
    assign refracted_y = o_reg[1];
    assign refracted_z = o_reg[2];

endmodule

>>> design/refraction_direction_top.sv
// ----------------------------------------------------------------------------
// refraction_direction_top
// Snell refraction of a unit direction through a surface, one ray per cycle when not stalled.
// ----------------------------------------------------------------------------
// Each request carries an incident direction and a surface normal (signed
// Q2.14) and the ratio n1/n2 (unsigned Q4.12); the block returns the refracted
// direction in Q2.14, saturated. A new request is taken every cycle while
// item_stall is low; there are eight vector stages (dot product, cosine clamp,
// P, |P|^2), five square-root stages of five root bits each, two output stages.
// Total internal reflection is not flagged; |1 - |P|^2| is used instead.
// Every stage has its own valid bit and moves when it is empty or the stage
// after it moves, so bubbles are squeezed out under a stalled output and
// item_stall only rises once the whole pipe is full.
// ----------------------------------------------------------------------------
module refraction_direction_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [rfd_pkg::CW-1:0] incident_x,
    input  logic signed [rfd_pkg::CW-1:0] incident_y,
    input  logic signed [rfd_pkg::CW-1:0] incident_z,
    input  logic signed [rfd_pkg::CW-1:0] normal_x,
    input  logic signed [rfd_pkg::CW-1:0] normal_y,
    input  logic signed [rfd_pkg::CW-1:0] normal_z,
    input  logic [rfd_pkg::CW-1:0]        refraction_ratio,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [rfd_pkg::CW-1:0] refracted_x,
    output logic signed [rfd_pkg::CW-1:0] refracted_y,
    output logic signed [rfd_pkg::CW-1:0] refracted_z
);

    localparam int NV = 8;                       // vector stages
    localparam int NQ = rfd_pkg::SQ_STAGES;      // sqrt stages
    localparam int NS = NV + NQ + 2;             // total depth

    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;

    logic [rfd_pkg::RAD_W-1:0] rad;
    logic [rfd_pkg::S_W-1:0]   root;
    rfd_pkg::side_t            side_v;
    rfd_pkg::side_t            side_q;

    // stage k loads when empty or when stage k+1 loads; last stage frees
    // when the result is taken
    always_comb
    begin
        logic up;
        up = !result_stall;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || up;
            up    = en[k];
        end
        v_next[0] = en[0] ? item_valid : v_reg[0];
        for (int k = 1; k < NS; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign item_stall   = !en[0];
    assign result_valid = v_reg[NS-1];

    rfd_vec u_vec (
        .clk              (clk),
        .en               (en[NV-1:0]),
        .incident_x       (incident_x),
        .incident_y       (incident_y),
        .incident_z       (incident_z),
        .normal_x         (normal_x),
        .normal_y         (normal_y),
        .normal_z         (normal_z),
        .refraction_ratio (refraction_ratio),
        .rad              (rad),
        .side             (side_v)
    );

    rfd_sqrt u_sqrt (
        .en       (en[NV+NQ-1:NV]),
        .clk      (clk),
        .rad      (rad),
        .side_in  (side_v),
        .root     (root),
        .side_out (side_q)
    );

    rfd_out u_out (
        .clk         (clk),
        .en          (en[NS-1:NV+NQ]),
        .root        (root),
        .side        (side_q),
        .refracted_x (refracted_x),
        .refracted_y (refracted_y),
        .refracted_z (refracted_z)
    );

    // an empty output stage never backs up the input
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> !item_stall)
        else $error("input stalled with empty output stage");

    // a free output never backs up the input
    a_free_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("input stalled while output is free");

    // an accepted request lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> v_reg[0])
        else $error("accepted request lost at first stage");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Snell refraction pipeline.
// ----------------------------------------------------------------------------
// A short directed set (field extremes, zero ratio, clamped cosine, total
// internal reflection, saturation) is followed by random rays, mostly unit
// vectors with ratios near one and some raw noise. Requests are driven with
// random idle cycles and results are taken under random stalls. A bit-exact
// predictor computes each expected refracted direction when its request is
// accepted.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = rfd_pkg::CW;
    localparam int N_RANDOM  = 1430;
    localparam int IDLE_PCT  = 31;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 40;

    typedef struct packed {
        logic signed [CW-1:0] ix, iy, iz;
        logic signed [CW-1:0] nx, ny, nz;
        logic [CW-1:0]        eta;
    } ray_t;

    typedef struct packed {
        logic signed [CW-1:0] x, y, z;
    } dir_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic signed [CW-1:0] incident_x, incident_y, incident_z;
    logic signed [CW-1:0] normal_x, normal_y, normal_z;
    logic [CW-1:0] refraction_ratio;
    logic result_valid;
    logic result_stall;
    logic signed [CW-1:0] refracted_x, refracted_y, refracted_z;

    ray_t pending_rays[$];
    dir_t expected_dirs[$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    bit   quiet_phase = 0;  // no idling on either side while set

    refraction_direction_top dut (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // floor(v / 2^k) after adding half an LSB
    function automatic longint round_down(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    // digit-by-digit floor square root
    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // bit-exact refraction: t, p, |P|^2, root, then saturated output
    function automatic dir_t refract(ray_t ray);
        longint inc[3], nrm[3], p[3], o[3];
        longint dot, cosv, len, diff, s, v;
        dir_t   res;
        inc = '{ray.ix, ray.iy, ray.iz};
        nrm = '{ray.nx, ray.ny, ray.nz};
        dot = 0;
        len = 0;
        for (int i = 0; i < 3; i++)
            dot += inc[i] * nrm[i];
        cosv = -dot;
        if (cosv > (longint'(1) << 28))
            cosv = longint'(1) << 28;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = round_down(round_down(inc[i] * (longint'(1) << 28) + cosv * nrm[i], 28)
                              * longint'(ray.eta), 12);
            len += p[i] * p[i];
        end
        diff = (longint'(1) << 28) - len;
        if (diff < 0)
            diff = -diff;
        s = int_sqrt(diff);
        for (int i = 0; i < 3; i++)
        begin
            v = round_down(p[i] * (longint'(1) << 14) - s * nrm[i], 14);
            o[i] = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
        end
        res.x = o[0][CW-1:0];
        res.y = o[1][CW-1:0];
        res.z = o[2][CW-1:0];
        return res;
    endfunction

    function automatic ray_t make_ray(int ix, int iy, int iz, int nx, int ny, int nz, int eta);
        ray_t r;
        r.ix = CW'(ix); r.iy = CW'(iy); r.iz = CW'(iz);
        r.nx = CW'(nx); r.ny = CW'(ny); r.nz = CW'(nz);
        r.eta = CW'(eta);
        return r;
    endfunction

    // random ray: unit-ish direction in Q2.14 along one dominant axis, or raw noise
    function automatic ray_t random_ray();
        ray_t r;
        int   a, b;
        if ($urandom_range(99) < 20)
            return ray_t'({$urandom, $urandom, $urandom, 16'($urandom)});
        a = $urandom_range(11585);
        b = $urandom_range(11585);
        r.ix = CW'($urandom_range(1) ? a : -a);
        r.iy = CW'($urandom_range(1) ? b : -b);
        r.iz = CW'(-int'(16384 - (a + b) / 3 + int'($urandom_range(200))));
        r.nx = CW'(int'($urandom_range(4000)) - 2000);
        r.ny = CW'(int'($urandom_range(4000)) - 2000);
        r.nz = CW'(16384 - int'($urandom_range(300)));
        if ($urandom_range(1))
            r.nz = -r.nz;
        r.eta = $urandom_range(3) == 0 ? CW'($urandom) : CW'(2048 + $urandom_range(4096));
        return r;
    endfunction

    initial
    begin
        // field extremes and special cases
        pending_rays.push_back(make_ray(0, 0, -16384, 0, 0, 16384, 4096));   // head-on, ratio one
        pending_rays.push_back(make_ray(11585, 0, -11585, 0, 0, 16384, 6144));
        pending_rays.push_back(make_ray(16384, 0, -100, 0, 0, 16384, 12288)); // internal reflection
        pending_rays.push_back(make_ray(5000, 300, -9000, 0, 0, 16384, 0));   // zero ratio
        pending_rays.push_back(make_ray(0, 0, -32768, 0, 0, 32767, 4096));    // cosine above one
        pending_rays.push_back(make_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535));
        pending_rays.push_back(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
        pending_rays.push_back(make_ray(-32768, 32767, 0, 32767, -32768, 0, 1));
        pending_rays.push_back(make_ray(0, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(-1, -1, -1, -1, -1, -1, 65535));
        pending_rays.push_back(make_ray(32767, 0, 0, 0, 32767, 0, 32768));
        pending_rays.push_back(make_ray(7000, -7000, 12000, 0, 16384, 0, 3000)); // non-unit mix
        for (int i = 0; i < N_RANDOM; i++)
            pending_rays.push_back(random_ray());
    end

    // driver: holds a request until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 0;
            {incident_x, incident_y, incident_z} <= '0;
            {normal_x, normal_y, normal_z, refraction_ratio} <= '0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (item_valid)
                expected_dirs.push_back(refract({incident_x, incident_y, incident_z,
                    normal_x, normal_y, normal_z, refraction_ratio}));
            if (pending_rays.size() > 0 &&
                (quiet_phase || $urandom_range(99) >= IDLE_PCT))
            begin
                ray_t r;
                r = pending_rays.pop_front();
                item_valid <= 1;
                incident_x <= r.ix; incident_y <= r.iy; incident_z <= r.iz;
                normal_x <= r.nx; normal_y <= r.ny; normal_z <= r.nz;
                refraction_ratio <= r.eta;
            end
            else
                item_valid <= 0;
        end
    end

    // monitor: random stalls, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                dir_t e;
                if (expected_dirs.size() == 0)
                begin
                    $display("%0t: result with no request pending: got %0d %0d %0d", $time,
                             refracted_x, refracted_y, refracted_z);
                    fail_count++;
                end
                else
                begin
                    e = expected_dirs.pop_front();
                    if (refracted_x !== e.x)
                    begin
                        $display("%0t: x expected %0d got %0d", $time, e.x, refracted_x);
                        fail_count++;
                    end
                    if (refracted_y !== e.y)
                    begin
                        $display("%0t: y expected %0d got %0d", $time, e.y, refracted_y);
                        fail_count++;
                    end
                    if (refracted_z !== e.z)
                    begin
                        $display("%0t: z expected %0d got %0d", $time, e.z, refracted_z);
                        fail_count++;
                    end
                end
            end
            result_stall <= !quiet_phase && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        // long stretch without idling partway through
        wait (pending_rays.size() < 900);
        quiet_phase = 1;
        wait (pending_rays.size() < 600);
        quiet_phase = 0;
        while (pending_rays.size() > 0 || item_valid || expected_dirs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (fail_count == 0 && expected_dirs.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
design/rfd_pkg.sv
design/rfd_vec.sv
design/rfd_sqrt.sv
design/rfd_out.sv
design/refraction_direction_top.sv
bench/tb_top.sv
